// ----- sv/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, codes and character helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // Default width of the size, remaining and total counters
  localparam int unsigned CountWidthDef = 32;

  // Reset value of the body size limit register
  localparam logic [31:0] MaxBodyRst = 32'h0010_0000;

  // Result kinds
  localparam logic [1:0] KindByte  = 2'd0;
  localparam logic [1:0] KindEnd   = 2'd1;
  localparam logic [1:0] KindBad   = 2'd2;
  localparam logic [1:0] KindLarge = 2'd3;

  // Framing characters
  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharLf = 8'h0a;

  // Decoder phase, one-hot
  typedef enum logic [5:0] {
    PH_SIZE    = 6'b000001,
    PH_SIZE_CR = 6'b000010,
    PH_DATA    = 6'b000100,
    PH_DATA_CR = 6'b001000,
    PH_DATA_LF = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_e;

  // Decoded hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_blank(input logic [7:0] c);
    return (c inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d});
  endfunction

endpackage

// ----- sv/http_chunked_body_decoder_top.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Decodes an HTTP/1.1 chunked body one byte per item: parses size lines,
// passes data bytes through, checks the trailing CR LF and the size limit.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  data     in         data_valid_i/data_stall_o data_byte_i
//  out      out        out_valid_o/out_stall_i   out_byte_o, out_kind_o
//  cfg      in         cfg_valid_i/cfg_ready_o   cfg_data_i (max body size)
//
//  One byte per cycle sustained while the output is not stalled. A byte is held
//  in the input register, then decoded against the line and chunk state in one
//  step and its result (if any) written to the output register.
//  Reset clears all decoding state and loads the limit with 1 MiB.
//  A stalled output holds the input register, which then stalls the input.
//  cfg_ready_o is always high; the limit is written whenever cfg_valid_i is high.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top #(
  parameter int unsigned COUNT_WIDTH = hcbd_pkg::CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        data_valid_i,
  output logic        data_stall_o,
  input  logic [7:0]  data_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  out_kind_o,
  // limit register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned SumW = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;

  // Size line state
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] accum;
    logic                   seen;
    logic                   stopped;
    logic                   ovf;
  } line_t;

  // One character of a size line (not a line-ending CR)
  function automatic line_t size_step(input line_t s, input logic [7:0] c);
    line_t         r;
    hcbd_pkg::hex_t h;
    r = s;
    h = hcbd_pkg::hex_decode(c);
    if (!s.stopped) begin
      if (h.ok) begin
        if (|s.accum[COUNT_WIDTH-1 -: 4]) r.ovf = 1'b1;
        r.accum = {s.accum[COUNT_WIDTH-5:0], h.val};
        r.seen  = 1'b1;
      end else if (s.seen || !hcbd_pkg::is_blank(c)) begin
        r.stopped = 1'b1;
      end
    end
    return r;
  endfunction

  logic [31:0]            max_body_q;
  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  hcbd_pkg::phase_e       phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] remain_q, remain_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  line_t                  line_q, line_d;
  line_t                  line_cr;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_byte_q;
  logic [1:0]             out_kind_q;
  logic                   adv;
  logic                   res_valid;
  logic [7:0]             res_byte;
  logic [1:0]             res_kind;
  logic [SumW-1:0]        new_total;
  logic [COUNT_WIDTH-1:0] remain_dec;

  // Limit register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= hcbd_pkg::MaxBodyRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_body_q <= cfg_data_i;
    end
  end

  // Handshake: input register moves on when the output register is free
  assign adv          = in_valid_q && (!out_valid_q || !out_stall_i);
  assign data_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (data_valid_i && !data_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_valid_i && !data_stall_o) begin
      in_byte_q <= data_byte_i;
    end
  end

  // Helpers for the decode step
  assign new_total = SumW'(total_q) + SumW'(line_q.accum);
  assign remain_dec = remain_q - COUNT_WIDTH'(1);

  // A lone CR seen in the size line acts as a non-hex character
  always_comb begin
    line_cr         = line_q;
    line_cr.stopped = line_q.stopped | line_q.seen;
  end

  // Decode step
  always_comb begin
    phase_d   = phase_q;
    remain_d  = remain_q;
    total_d   = total_q;
    line_d    = line_q;
    res_valid = 1'b0;
    res_byte  = 8'd0;
    res_kind  = hcbd_pkg::KindByte;
    if (adv) begin
      case (phase_q)
        hcbd_pkg::PH_SIZE: begin
          if (in_byte_q == hcbd_pkg::CharCr) begin
            phase_d = hcbd_pkg::PH_SIZE_CR;
          end else begin
            line_d = size_step(line_q, in_byte_q);
          end
        end
        hcbd_pkg::PH_SIZE_CR: begin
          if (in_byte_q == hcbd_pkg::CharLf) begin
            // end of size line
            res_valid = 1'b1;
            phase_d   = hcbd_pkg::PH_DONE;
            if (line_q.ovf) begin
              res_kind = hcbd_pkg::KindLarge;
            end else if (!line_q.seen || line_q.accum == '0) begin
              res_kind = hcbd_pkg::KindEnd;
            end else if (new_total > SumW'(max_body_q)) begin
              res_kind = hcbd_pkg::KindLarge;
            end else begin
              res_valid = 1'b0;
              total_d   = new_total[COUNT_WIDTH-1:0];
              remain_d  = line_q.accum;
              phase_d   = hcbd_pkg::PH_DATA;
            end
          end else if (in_byte_q == hcbd_pkg::CharCr) begin
            line_d = line_cr;
          end else begin
            line_d  = size_step(line_cr, in_byte_q);
            phase_d = hcbd_pkg::PH_SIZE;
          end
        end
        hcbd_pkg::PH_DATA: begin
          remain_d  = remain_dec;
          if (remain_dec == '0) phase_d = hcbd_pkg::PH_DATA_CR;
          res_valid = 1'b1;
          res_byte  = in_byte_q;
        end
        hcbd_pkg::PH_DATA_CR: begin
          if (in_byte_q == hcbd_pkg::CharCr) begin
            phase_d = hcbd_pkg::PH_DATA_LF;
          end else begin
            phase_d   = hcbd_pkg::PH_DONE;
            res_valid = 1'b1;
            res_kind  = hcbd_pkg::KindBad;
          end
        end
        hcbd_pkg::PH_DATA_LF: begin
          if (in_byte_q == hcbd_pkg::CharLf) begin
            phase_d = hcbd_pkg::PH_SIZE;
            line_d  = '0;
          end else begin
            phase_d   = hcbd_pkg::PH_DONE;
            res_valid = 1'b1;
            res_kind  = hcbd_pkg::KindBad;
          end
        end
        default: begin
          // finished: bytes are dropped
        end
      endcase
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hcbd_pkg::PH_SIZE;
      remain_q <= '0;
      total_q  <= '0;
      line_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      total_q  <= total_d;
      line_q   <= line_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_byte_q <= res_byte;
      out_kind_q <= res_kind;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_kind_o  = out_kind_q;

  // Checks
  a_end_means_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o != hcbd_pkg::KindByte) |-> phase_q == hcbd_pkg::PH_DONE)
    else $error("end or error result without finished phase");

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hcbd_pkg::PH_DONE) |=> (phase_q == hcbd_pkg::PH_DONE))
    else $error("decoder left finished phase");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hcbd_pkg::PH_DATA) |-> (remain_q != '0))
    else $error("data phase with no bytes remaining");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with no item held");

endmodule

// ----- test/tb_http_chunked_body_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_top
// Self-checking bench for the chunked body decoder. A short table of
// hand-picked bytes is followed by random, well-formed chunks under several
// size limits. The body is then closed by one randomly chosen ending (zero
// size, no size digits, framing error, limit hit or size overflow), followed by
// bytes that must be ignored. Every result is compared with a bit-accurate
// decoder model kept in this bench, or with the result typed into the table.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder_top;

  localparam int WDOG_LIMIT = 2000;
  localparam int RAND_ITEMS = 450;
  localparam int LONG_HOLD  = 60;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } dec_res_t;

  // One directed row: byte in, and the result where it is typed in by hand
  typedef struct packed {
    logic [7:0] c;
    logic       typed;
    logic [7:0] wb;
    logic [1:0] wk;
  } dir_row_t;

  // How the body is brought to an end
  typedef enum int {
    END_ZERO, END_NODIG, END_BADCR, END_BADLF, END_LARGE, END_OVF
  } body_end_e;

  localparam logic [7:0] BLANK_SET [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

  // blanks, extension, lone CR and CR CR LF in size lines; extreme data bytes
  localparam dir_row_t DIR_TAB [22] = '{
    '{8'h20, 1'b0, 8'h00, hcbd_pkg::KindByte},   // leading space
    '{8'h09, 1'b0, 8'h00, hcbd_pkg::KindByte},   // leading tab
    '{8'h30, 1'b0, 8'h00, hcbd_pkg::KindByte},   // "0"
    '{8'h32, 1'b0, 8'h00, hcbd_pkg::KindByte},   // "2"
    '{8'h3b, 1'b0, 8'h00, hcbd_pkg::KindByte},   // ";" starts extension
    '{8'h78, 1'b0, 8'h00, hcbd_pkg::KindByte},   // "x" in extension
    '{hcbd_pkg::CharCr, 1'b0, 8'h00, hcbd_pkg::KindByte},
    '{hcbd_pkg::CharLf, 1'b0, 8'h00, hcbd_pkg::KindByte},
    '{8'h00, 1'b1, 8'h00, hcbd_pkg::KindByte},   // lowest data byte
    '{8'hff, 1'b1, 8'hff, hcbd_pkg::KindByte},   // highest data byte
    '{hcbd_pkg::CharCr, 1'b0, 8'h00, hcbd_pkg::KindByte},
    '{hcbd_pkg::CharLf, 1'b0, 8'h00, hcbd_pkg::KindByte},
    '{hcbd_pkg::CharCr, 1'b0, 8'h00, hcbd_pkg::KindByte},  // lone CR before the digits
    '{8'h31, 1'b0, 8'h00, hcbd_pkg::KindByte},   // "1"
    '{hcbd_pkg::CharCr, 1'b0, 8'h00, hcbd_pkg::KindByte},  // lone CR after the digits
    '{8'h7a, 1'b0, 8'h00, hcbd_pkg::KindByte},   // "z"
    '{hcbd_pkg::CharCr, 1'b0, 8'h00, hcbd_pkg::KindByte},  // CR CR LF ends the line
    '{hcbd_pkg::CharCr, 1'b0, 8'h00, hcbd_pkg::KindByte},
    '{hcbd_pkg::CharLf, 1'b0, 8'h00, hcbd_pkg::KindByte},
    '{hcbd_pkg::CharCr, 1'b1, hcbd_pkg::CharCr, hcbd_pkg::KindByte}, // CR as data
    '{hcbd_pkg::CharCr, 1'b0, 8'h00, hcbd_pkg::KindByte},
    '{hcbd_pkg::CharLf, 1'b0, 8'h00, hcbd_pkg::KindByte}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        data_valid_i;
  logic        data_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic [1:0]  out_kind_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;

  // Decoder model state
  hcbd_pkg::phase_e dec_ph;
  logic [31:0] max_body;
  logic [31:0] chunk_left;
  logic [31:0] body_sum;
  logic [31:0] line_val;
  logic        line_digits;
  logic        line_stop;
  logic        line_ovf;

  dec_res_t want_q[$];
  dec_res_t head_r;

  int  n_in, n_out, n_body, n_cfg, n_bad;
  bit  tx_quiet, rx_quiet, rx_hold_req;

  http_chunked_body_decoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_valid_i (data_valid_i),
    .data_stall_o (data_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_kind_o   (out_kind_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------
  function automatic bit hex_nib(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0b || c == 8'h0c ||
           c == 8'h0d;
  endfunction

  function automatic void line_clear();
    line_val    = '0;
    line_digits = 1'b0;
    line_stop   = 1'b0;
    line_ovf    = 1'b0;
  endfunction

  function automatic void model_reset();
    max_body   = hcbd_pkg::MaxBodyRst;
    dec_ph     = hcbd_pkg::PH_SIZE;
    chunk_left = '0;
    body_sum   = '0;
    line_clear();
  endfunction

  // one size-line character other than a CR that may end the line
  function automatic void line_char(input logic [7:0] c);
    logic [3:0] v;
    if (line_stop) return;
    if (hex_nib(c, v)) begin
      if (line_val[31:28] != 4'h0) line_ovf = 1'b1;
      line_val    = {line_val[27:0], v};
      line_digits = 1'b1;
    end else if (line_digits || !blank_char(c)) begin
      line_stop = 1'b1;
    end
  endfunction

  // end of size line: start the chunk or close the body
  function automatic bit close_line(output dec_res_t r);
    r = '0;
    if (line_ovf) begin
      dec_ph = hcbd_pkg::PH_DONE;
      r.kind = hcbd_pkg::KindLarge;
      return 1'b1;
    end
    if (!line_digits || line_val == 0) begin
      dec_ph = hcbd_pkg::PH_DONE;
      r.kind = hcbd_pkg::KindEnd;
      return 1'b1;
    end
    if (line_val > max_body || body_sum > max_body - line_val) begin
      dec_ph = hcbd_pkg::PH_DONE;
      r.kind = hcbd_pkg::KindLarge;
      return 1'b1;
    end
    body_sum   = body_sum + line_val;
    chunk_left = line_val;
    dec_ph     = hcbd_pkg::PH_DATA;
    return 1'b0;
  endfunction

  function automatic bit decode_step(input logic [7:0] c, output dec_res_t r);
    bit has;
    has = 1'b0;
    r   = '0;
    case (dec_ph)
      hcbd_pkg::PH_SIZE: begin
        if (c == hcbd_pkg::CharCr) dec_ph = hcbd_pkg::PH_SIZE_CR;
        else line_char(c);
      end
      hcbd_pkg::PH_SIZE_CR: begin
        if (c == hcbd_pkg::CharLf) begin
          has = close_line(r);
        end else if (c == hcbd_pkg::CharCr) begin
          line_char(hcbd_pkg::CharCr);
        end else begin
          line_char(hcbd_pkg::CharCr);
          line_char(c);
          dec_ph = hcbd_pkg::PH_SIZE;
        end
      end
      hcbd_pkg::PH_DATA: begin
        chunk_left = chunk_left - 1;
        if (chunk_left == 0) dec_ph = hcbd_pkg::PH_DATA_CR;
        r.data = c;
        r.kind = hcbd_pkg::KindByte;
        has    = 1'b1;
      end
      hcbd_pkg::PH_DATA_CR: begin
        if (c == hcbd_pkg::CharCr) begin
          dec_ph = hcbd_pkg::PH_DATA_LF;
        end else begin
          dec_ph = hcbd_pkg::PH_DONE;
          r.kind = hcbd_pkg::KindBad;
          has    = 1'b1;
        end
      end
      hcbd_pkg::PH_DATA_LF: begin
        if (c == hcbd_pkg::CharLf) begin
          dec_ph = hcbd_pkg::PH_SIZE;
          line_clear();
        end else begin
          dec_ph = hcbd_pkg::PH_DONE;
          r.kind = hcbd_pkg::KindBad;
          has    = 1'b1;
        end
      end
      default: ;
    endcase
    return has;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit up);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (up ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic int hex_len(input logic [31:0] v);
    int d;
    d = 1;
    while (d < 8 && (v >> (4 * d)) != 0) d++;
    return d;
  endfunction

  // offer one byte after a random gap; predict once it is taken
  task automatic push_byte(input logic [7:0] c, input bit typed, input dec_res_t want);
    int       gap;
    bit       has;
    dec_res_t r;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      data_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    data_valid_i <= 1'b1;
    data_byte_i  <= c;
    do @(posedge clk_i); while (data_stall_o);
    has = decode_step(c, r);
    if (typed) begin
      has = 1'b1;
      r   = want;
    end
    if (has) want_q.push_back(r);
    n_in++;
  endtask

  task automatic push_rand(input int n);
    repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // size line: optional blanks, ndig hex digits, optional extension, optional extra CR, CR LF
  task automatic send_line(input logic [63:0] val, input int ndig);
    logic [7:0] q[$];
    logic [7:0] b;
    int         k;
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = BLANK_SET[$urandom_range(0, 5)];
        if (q.size() > 0 && q[$] == hcbd_pkg::CharCr && b == hcbd_pkg::CharLf) b = 8'h20;
        q.push_back(b);
      end
    end
    for (int i = ndig - 1; i >= 0; i--)
      q.push_back(hex_char(i < 16 ? val[4 * i +: 4] : 4'h0, 1'($urandom_range(0, 1))));
    if ($urandom_range(0, 2) == 0) begin
      logic [3:0] dummy;
      // extension must open with a non-hex, non-blank byte
      do b = 8'($urandom_range(0, 255)); while (hex_nib(b, dummy) || blank_char(b));
      q.push_back(b);
      k = $urandom_range(0, 4);
      repeat (k) begin
        b = 8'($urandom_range(0, 255));
        if (q[$] == hcbd_pkg::CharCr && b == hcbd_pkg::CharLf) b = 8'h2c;
        q.push_back(b);
      end
    end
    if ($urandom_range(0, 3) == 0) q.push_back(hcbd_pkg::CharCr);
    q.push_back(hcbd_pkg::CharCr);
    q.push_back(hcbd_pkg::CharLf);
    foreach (q[i]) push_byte(q[i], 1'b0, '0);
  endtask

  task automatic send_chunk(input logic [31:0] size);
    int nz;
    nz = ($urandom_range(0, 9) == 0) ? 9 : $urandom_range(0, 2);
    send_line({32'h0, size}, hex_len(size) + nz);
    push_rand(size);
    push_byte(hcbd_pkg::CharCr, 1'b0, '0);
    push_byte(hcbd_pkg::CharLf, 1'b0, '0);
  endtask

  // input idle and every expected result in, then room for the pipeline
  task automatic settle();
    @(negedge clk_i);
    data_valid_i <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    max_body = v;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        n           = LONG_HOLD;
        rx_hold_req = 1'b0;
      end else begin
        n = rx_quiet ? 0 : $urandom_range(0, 17);
      end
      if (n > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) begin
      n_out++;
      if (want_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: unexpected result kind %0d byte %02h", $realtime,
                   out_kind_o, out_byte_o);
      end else begin
        head_r = want_q.pop_front();
        if (head_r.kind == hcbd_pkg::KindByte) n_body++;
        if (out_kind_o !== head_r.kind || out_byte_o !== head_r.data) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: got kind %0d byte %02h, expected kind %0d byte %02h",
                     $realtime, out_kind_o, out_byte_o, head_r.kind, head_r.data);
        end
      end
    end
  end

  // Watchdog: nothing moving on any channel for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WDOG_LIMIT) begin
      @(posedge clk_i);
      if ((data_valid_i && !data_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
             WDOG_LIMIT, want_q.size());
    $display("http_chunked_body_decoder_top: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [31:0] sizes[$];
    logic [31:0] s;
    longint      tot;
    longint      lim;
    int          ph_idx;
    int          n_noise;
    body_end_e   how;

    rst_ni       = 1'b0;
    data_valid_i = 1'b0;
    data_byte_i  = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    rx_hold_req  = 1'b0;
    model_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table under the reset limit
    foreach (DIR_TAB[i])
      push_byte(DIR_TAB[i].c, DIR_TAB[i].typed, '{DIR_TAB[i].wb, DIR_TAB[i].wk});

    // random phases of well-formed chunks, new limit per phase
    ph_idx = 0;
    while (n_in < RAND_ITEMS) begin
      settle();
      sizes.delete();
      tot = 0;
      repeat ($urandom_range(1, 6)) begin
        s = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 24);
        sizes.push_back(s);
      end
      if (ph_idx == 1) sizes[0] = 40;
      foreach (sizes[i]) tot += sizes[i];
      case ((ph_idx == 0) ? 0 : $urandom_range(0, 2))
        0:       lim = 64'hFFFF_FFFF;
        1:       lim = body_sum + tot;   // the last chunk lands exactly on the limit
        default: lim = body_sum + tot + $urandom_range(0, 32'hFFFF_FFFF - 32'(body_sum + tot));
      endcase
      write_limit(lim[31:0]);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (ph_idx == 1) begin
        // receiver holds off while the sender streams: the block must back up
        tx_quiet    = 1'b1;
        rx_hold_req = 1'b1;
      end
      foreach (sizes[i]) send_chunk(sizes[i]);
      ph_idx++;
    end

    // close the body one way or another
    settle();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    how      = body_end_e'($urandom_range(0, 5));
    case (how)
      END_ZERO:  send_line(64'h0, $urandom_range(1, 3));
      END_NODIG: send_line(64'h0, 0);
      END_BADCR, END_BADLF: begin
        s = $urandom_range(1, 8);
        send_line({32'h0, s}, hex_len(s));
        push_rand(s);
        if (how == END_BADLF) begin
          push_byte(hcbd_pkg::CharCr, 1'b0, '0);
          do s = $urandom_range(0, 255); while (s[7:0] == hcbd_pkg::CharLf);
        end else begin
          do s = $urandom_range(0, 255); while (s[7:0] == hcbd_pkg::CharCr);
        end
        push_byte(s[7:0], 1'b0, '0);
      end
      END_LARGE: begin
        s = $urandom_range(1, 32'hFFFF_0000);
        write_limit(($urandom_range(0, 1) == 0) ? 32'h0 : body_sum + s - 1);
        send_line({32'h0, s}, hex_len(s));
      end
      default: send_line({28'h0, 4'h1, 32'($urandom())}, 9);  // nine digits
    endcase

    // once closed, every byte is ignored whatever the limit
    settle();
    write_limit(32'h0);
    n_noise = n_in;
    push_rand(12);
    n_noise = n_in - n_noise;
    settle();
    repeat (8) @(posedge clk_i);

    $display("covered %0d bytes in, %0d results out (%0d body bytes), %0d limit writes",
             n_in, n_out, n_body, n_cfg);
    $display("body closed by %s, then %0d ignored bytes; %0d mismatches",
             how.name(), n_noise, n_bad);
    if (n_bad == 0 && want_q.size() == 0)
      $display("http_chunked_body_decoder_top: match");
    else
      $display("http_chunked_body_decoder_top: mismatch");
    $finish;
  end

endmodule
